// File: rtl/aesd_pkg.sv
// Package for the accelerometer EMA step detector.
// Field widths, fixed-point and reciprocal constants, register indexes.
// No dependencies.
`default_nettype none

package aesd_pkg;

    localparam int SEED_COUNT = 16;
    localparam int FRAC_BITS  = 8;

    localparam int SMP_W      = 16;
    localparam int TIME_W     = 32;
    localparam int LOCK_W     = 16;
    localparam int THR_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CNT_W = $clog2(SEED_COUNT + 1);
    localparam int SUM_W = SMP_W + $clog2(SEED_COUNT);
    localparam int AVG_W = ((SUM_W > SMP_W + FRAC_BITS) ? SUM_W : SMP_W + FRAC_BITS) + 1;
    localparam int CMP_W = AVG_W + 2;

    // floor(n / (SEED_COUNT+1)) by multiply with a rounded-up reciprocal
    localparam int EMA_D   = SEED_COUNT + 1;
    localparam int EMA_N   = AVG_W + 2;
    localparam int EMA_K   = EMA_N + $clog2(EMA_D);
    localparam int EMA_M_W = EMA_N + 1;
    localparam logic [63:0] EMA_M_FULL = ((64'd1 << EMA_K) + 64'(EMA_D) - 64'd1) / 64'(EMA_D);
    localparam logic [EMA_M_W-1:0] EMA_M = EMA_M_FULL[EMA_M_W-1:0];

    // floor(n / SEED_COUNT) the same way
    localparam int SEED_N   = SUM_W + FRAC_BITS + 1;
    localparam int SEED_K   = SEED_N + $clog2(SEED_COUNT);
    localparam int SEED_M_W = SEED_N + 1;
    localparam logic [63:0] SEED_M_FULL =
        ((64'd1 << SEED_K) + 64'(SEED_COUNT) - 64'd1) / 64'(SEED_COUNT);
    localparam logic [SEED_M_W-1:0] SEED_M = SEED_M_FULL[SEED_M_W-1:0];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LOCKOUT = 3'd0,
        CFG_Y_LOCKOUT = 3'd1,
        CFG_Z_LOCKOUT = 3'd2,
        CFG_X_RISE    = 3'd3,
        CFG_Y_RISE    = 3'd4,
        CFG_Z_RISE    = 3'd5,
        CFG_X_REARM   = 3'd6
    } t_cfg_idx;

    localparam logic [LOCK_W-1:0] RST_X_LOCKOUT = 16'd150;
    localparam logic [LOCK_W-1:0] RST_Y_LOCKOUT = 16'd350;
    localparam logic [LOCK_W-1:0] RST_Z_LOCKOUT = 16'd350;
    localparam logic [THR_W-1:0]  RST_X_RISE    = 15'd170;
    localparam logic [THR_W-1:0]  RST_Y_RISE    = 15'd150;
    localparam logic [THR_W-1:0]  RST_Z_RISE    = 15'd150;
    localparam logic [THR_W-1:0]  RST_X_REARM   = 15'd45;

endpackage

`default_nettype wire

// File: rtl/accel_ema_step_detector.sv
// Top level of the accelerometer EMA step detector.
// Uses aesd_pkg for widths, reciprocal constants and register indexes.
// Input register, combinational average update and step check, result register.
`default_nettype none

// One item enters per cycle unless the input register is full and output stalls;
// each yields exactly one result, via input register and then result register.
// Rate is set by the per-axis average update and step check, combinational on
// the state registers. A waiting result lets only an empty input register fill.
// The first SEED_COUNT items only build the averages and return seeding = 1.
// No clearing pass after reset; configuration writes take effect at once.
module accel_ema_step_detector (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [aesd_pkg::SMP_W-1:0]   i_x_sample,
    input  wire logic signed [aesd_pkg::SMP_W-1:0]   i_y_sample,
    input  wire logic signed [aesd_pkg::SMP_W-1:0]   i_z_sample,
    input  wire logic        [aesd_pkg::TIME_W-1:0]  i_time_ms,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_step_flag,
    output logic                                     o_seeding,
    input  wire logic                                i_cfg_we,
    input  wire logic [aesd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [aesd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // avg + floor(2 * (s * 2^F - avg) / (SEED_COUNT + 1))
    function automatic logic signed [aesd_pkg::AVG_W-1:0] f_ema(
        input logic signed [aesd_pkg::AVG_W-1:0] avg,
        input logic signed [aesd_pkg::SMP_W-1:0] s
    );
        logic signed [aesd_pkg::AVG_W+1:0] sx;
        logic signed [aesd_pkg::AVG_W+1:0] ax;
        logic signed [aesd_pkg::AVG_W+1:0] n;
        logic [aesd_pkg::EMA_N-1:0] u;
        logic [aesd_pkg::EMA_N+aesd_pkg::EMA_M_W-1:0] p;
        logic [aesd_pkg::EMA_N-1:0] q;
        logic signed [aesd_pkg::AVG_W+1:0] fq;
        sx = (aesd_pkg::AVG_W+2)'(s) <<< aesd_pkg::FRAC_BITS;
        ax = (aesd_pkg::AVG_W+2)'(avg);
        n  = (sx - ax) <<< 1;
        if (n < 0) begin
            u = aesd_pkg::EMA_N'(-n) + aesd_pkg::EMA_N'(aesd_pkg::EMA_D - 1);
        end else begin
            u = aesd_pkg::EMA_N'(n);
        end
        p  = (aesd_pkg::EMA_N+aesd_pkg::EMA_M_W)'(u) * aesd_pkg::EMA_M;
        q  = aesd_pkg::EMA_N'(p >> aesd_pkg::EMA_K);
        fq = (n < 0) ? -$signed((aesd_pkg::AVG_W+2)'(q)) : $signed((aesd_pkg::AVG_W+2)'(q));
        return aesd_pkg::AVG_W'(ax + fq);
    endfunction

    // floor(sum * 2^F / SEED_COUNT)
    function automatic logic signed [aesd_pkg::AVG_W-1:0] f_seed(
        input logic signed [aesd_pkg::SUM_W-1:0] sum
    );
        logic signed [aesd_pkg::SEED_N-1:0] n;
        logic [aesd_pkg::SEED_N-1:0] u;
        logic [aesd_pkg::SEED_N+aesd_pkg::SEED_M_W-1:0] p;
        logic [aesd_pkg::SEED_N-1:0] q;
        logic signed [aesd_pkg::SEED_N:0] fq;
        n = aesd_pkg::SEED_N'(sum) <<< aesd_pkg::FRAC_BITS;
        if (n < 0) begin
            u = aesd_pkg::SEED_N'(-n) + aesd_pkg::SEED_N'(aesd_pkg::SEED_COUNT - 1);
        end else begin
            u = aesd_pkg::SEED_N'(n);
        end
        p  = (aesd_pkg::SEED_N+aesd_pkg::SEED_M_W)'(u) * aesd_pkg::SEED_M;
        q  = aesd_pkg::SEED_N'(p >> aesd_pkg::SEED_K);
        fq = (n < 0) ? -$signed((aesd_pkg::SEED_N+1)'(q)) : $signed((aesd_pkg::SEED_N+1)'(q));
        return aesd_pkg::AVG_W'(fq);
    endfunction

    // configuration
    logic [aesd_pkg::LOCK_W-1:0] r_x_lockout, r_y_lockout, r_z_lockout;
    logic [aesd_pkg::THR_W-1:0]  r_x_rise, r_y_rise, r_z_rise, r_x_rearm;

    // input stage
    logic                                r_in_valid;
    logic signed [aesd_pkg::SMP_W-1:0]   r_x, r_y, r_z;
    logic        [aesd_pkg::TIME_W-1:0]  r_time;

    // detector state
    logic signed [aesd_pkg::AVG_W-1:0]   r_x_avg, r_y_avg, r_z_avg;
    logic        [aesd_pkg::CNT_W-1:0]   r_seed_cnt;
    logic                                r_armed;
    logic        [aesd_pkg::TIME_W-1:0]  r_last_time;

    // result stage
    logic r_out_valid, r_step, r_seeding;

    logic w_adv, w_fire;

    logic [aesd_pkg::SMP_W-2:0]          w_y_abs, w_z_abs;
    logic signed [aesd_pkg::SMP_W-1:0]   w_y, w_z;
    logic                                w_seeding, w_seed_last;
    logic signed [aesd_pkg::SUM_W-1:0]   w_x_sum, w_y_sum, w_z_sum;
    logic signed [aesd_pkg::AVG_W-1:0]   w_x_ema, w_y_ema, w_z_ema;
    logic signed [aesd_pkg::CMP_W-1:0]   w_xs, w_ys, w_zs;
    logic signed [aesd_pkg::CMP_W-1:0]   w_xa, w_ya, w_za;
    logic                                w_rearm, w_armed_mid;
    logic                                w_x_rise_ok, w_y_rise_ok, w_z_rise_ok;
    logic                                w_x_lock_ok, w_y_lock_ok, w_z_lock_ok;
    logic                                w_x_hit, w_y_hit, w_z_hit, w_step;

    logic signed [aesd_pkg::AVG_W-1:0]   n_x_avg, n_y_avg, n_z_avg;
    logic        [aesd_pkg::CNT_W-1:0]   n_seed_cnt;
    logic                                n_armed;
    logic        [aesd_pkg::TIME_W-1:0]  n_last_time;
    logic                                n_step;

    assign w_adv   = !r_out_valid || i_ready;
    assign w_fire  = r_in_valid && w_adv;
    assign o_ready = !r_in_valid || w_adv;

    assign o_valid     = r_out_valid;
    assign o_step_flag = r_step;
    assign o_seeding   = r_seeding;

    // absolute value, most negative code saturates
    assign w_y_abs = (r_y == $signed({1'b1, {(aesd_pkg::SMP_W-1){1'b0}}})) ?
                     {(aesd_pkg::SMP_W-1){1'b1}} :
                     (r_y < 0) ? (aesd_pkg::SMP_W-1)'(-r_y) : (aesd_pkg::SMP_W-1)'(r_y);
    assign w_z_abs = (r_z == $signed({1'b1, {(aesd_pkg::SMP_W-1){1'b0}}})) ?
                     {(aesd_pkg::SMP_W-1){1'b1}} :
                     (r_z < 0) ? (aesd_pkg::SMP_W-1)'(-r_z) : (aesd_pkg::SMP_W-1)'(r_z);
    assign w_y = $signed({1'b0, w_y_abs});
    assign w_z = $signed({1'b0, w_z_abs});

    function automatic logic f_lock_ok(
        input logic [aesd_pkg::TIME_W-1:0] now,
        input logic [aesd_pkg::TIME_W-1:0] last,
        input logic [aesd_pkg::LOCK_W-1:0] lock
    );
        logic [aesd_pkg::TIME_W:0] lim;
        lim = {1'b0, last} + (aesd_pkg::TIME_W+1)'(lock);
        return {1'b0, now} >= lim;
    endfunction

    function automatic logic signed [aesd_pkg::CMP_W-1:0] f_thr(
        input logic [aesd_pkg::THR_W-1:0] thr
    );
        return $signed((aesd_pkg::CMP_W)'(thr)) <<< aesd_pkg::FRAC_BITS;
    endfunction

    always_comb begin
        w_seeding   = r_seed_cnt < aesd_pkg::CNT_W'(aesd_pkg::SEED_COUNT);
        w_seed_last = r_seed_cnt == aesd_pkg::CNT_W'(aesd_pkg::SEED_COUNT - 1);

        w_x_sum = aesd_pkg::SUM_W'(r_x_avg) + aesd_pkg::SUM_W'(r_x);
        w_y_sum = aesd_pkg::SUM_W'(r_y_avg) + aesd_pkg::SUM_W'(w_y);
        w_z_sum = aesd_pkg::SUM_W'(r_z_avg) + aesd_pkg::SUM_W'(w_z);

        w_x_ema = f_ema(r_x_avg, r_x);
        w_y_ema = f_ema(r_y_avg, w_y);
        w_z_ema = f_ema(r_z_avg, w_z);

        w_xs = aesd_pkg::CMP_W'(r_x) <<< aesd_pkg::FRAC_BITS;
        w_ys = aesd_pkg::CMP_W'(w_y) <<< aesd_pkg::FRAC_BITS;
        w_zs = aesd_pkg::CMP_W'(w_z) <<< aesd_pkg::FRAC_BITS;
        w_xa = aesd_pkg::CMP_W'(w_x_ema);
        w_ya = aesd_pkg::CMP_W'(w_y_ema);
        w_za = aesd_pkg::CMP_W'(w_z_ema);

        w_rearm     = w_xs < (w_xa - f_thr(r_x_rearm));
        w_armed_mid = r_armed || w_rearm;
        w_x_rise_ok = w_xs >  (w_xa + f_thr(r_x_rise));
        w_y_rise_ok = w_ys >= (w_ya + f_thr(r_y_rise));
        w_z_rise_ok = w_zs >= (w_za + f_thr(r_z_rise));
        w_x_lock_ok = f_lock_ok(r_time, r_last_time, r_x_lockout);
        w_y_lock_ok = f_lock_ok(r_time, r_last_time, r_y_lockout);
        w_z_lock_ok = f_lock_ok(r_time, r_last_time, r_z_lockout);

        // x first; y and z only if no earlier axis fired
        w_x_hit = w_armed_mid && w_x_lock_ok && w_x_rise_ok;
        w_y_hit = !w_x_hit && w_armed_mid && w_y_lock_ok && w_y_rise_ok;
        w_z_hit = !w_x_hit && !w_y_hit && w_armed_mid && w_z_lock_ok && w_z_rise_ok;
        w_step  = w_x_hit || w_y_hit || w_z_hit;

        n_x_avg     = r_x_avg;
        n_y_avg     = r_y_avg;
        n_z_avg     = r_z_avg;
        n_seed_cnt  = r_seed_cnt;
        n_armed     = r_armed;
        n_last_time = r_last_time;
        n_step      = 1'b0;
        if (w_seeding) begin
            n_seed_cnt = r_seed_cnt + aesd_pkg::CNT_W'(1);
            if (w_seed_last) begin
                n_x_avg = f_seed(w_x_sum);
                n_y_avg = f_seed(w_y_sum);
                n_z_avg = f_seed(w_z_sum);
            end else begin
                n_x_avg = aesd_pkg::AVG_W'(w_x_sum);
                n_y_avg = aesd_pkg::AVG_W'(w_y_sum);
                n_z_avg = aesd_pkg::AVG_W'(w_z_sum);
            end
        end else begin
            n_x_avg = w_x_ema;
            n_y_avg = w_y_ema;
            n_z_avg = w_z_ema;
            n_armed = w_armed_mid && !w_x_hit;
            n_step  = w_step;
            if (w_step) begin
                n_last_time = r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lockout <= aesd_pkg::RST_X_LOCKOUT;
            r_y_lockout <= aesd_pkg::RST_Y_LOCKOUT;
            r_z_lockout <= aesd_pkg::RST_Z_LOCKOUT;
            r_x_rise    <= aesd_pkg::RST_X_RISE;
            r_y_rise    <= aesd_pkg::RST_Y_RISE;
            r_z_rise    <= aesd_pkg::RST_Z_RISE;
            r_x_rearm   <= aesd_pkg::RST_X_REARM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aesd_pkg::CFG_X_LOCKOUT: r_x_lockout <= i_cfg_data;
                aesd_pkg::CFG_Y_LOCKOUT: r_y_lockout <= i_cfg_data;
                aesd_pkg::CFG_Z_LOCKOUT: r_z_lockout <= i_cfg_data;
                aesd_pkg::CFG_X_RISE:    r_x_rise    <= i_cfg_data[aesd_pkg::THR_W-1:0];
                aesd_pkg::CFG_Y_RISE:    r_y_rise    <= i_cfg_data[aesd_pkg::THR_W-1:0];
                aesd_pkg::CFG_Z_RISE:    r_z_rise    <= i_cfg_data[aesd_pkg::THR_W-1:0];
                aesd_pkg::CFG_X_REARM:   r_x_rearm   <= i_cfg_data[aesd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_x    <= i_x_sample;
            r_y    <= i_y_sample;
            r_z    <= i_z_sample;
            r_time <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_avg     <= '0;
            r_y_avg     <= '0;
            r_z_avg     <= '0;
            r_seed_cnt  <= '0;
            r_armed     <= 1'b1;
            r_last_time <= '0;
        end else if (w_fire) begin
            r_x_avg     <= n_x_avg;
            r_y_avg     <= n_y_avg;
            r_z_avg     <= n_z_avg;
            r_seed_cnt  <= n_seed_cnt;
            r_armed     <= n_armed;
            r_last_time <= n_last_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_step    <= n_step;
            r_seeding <= w_seeding;
        end
    end

endmodule

`default_nettype wire

// File: rtl/aesd_checker.sv
// Port-level checker for accel_ema_step_detector, bound to the top level.
// Uses aesd_pkg for port widths.
`default_nettype none

module aesd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_ready,
    input wire logic signed [aesd_pkg::SMP_W-1:0]   i_x_sample,
    input wire logic signed [aesd_pkg::SMP_W-1:0]   i_y_sample,
    input wire logic signed [aesd_pkg::SMP_W-1:0]   i_z_sample,
    input wire logic        [aesd_pkg::TIME_W-1:0]  i_time_ms,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic                                o_step_flag,
    input wire logic                                o_seeding
);

    // set once a non-seeding item has been delivered
    logic r_seed_done;
    logic n_seed_done;

    assign n_seed_done = r_seed_done || (o_valid && i_ready && !o_seeding);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_done <= 1'b0;
        end else begin
            r_seed_done <= n_seed_done;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_step_flag) && $stable(o_seeding)))
        else $error("result item changed while stalled");

    a_no_step_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_step_flag && o_seeding))
        else $error("step flagged during seeding");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty result register");

    a_seeding_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_seed_done) |-> !o_seeding)
        else $error("seeding item after seeding ended");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=>
            (i_valid && $stable(i_x_sample) && $stable(i_y_sample) &&
             $stable(i_z_sample) && $stable(i_time_ms)))
        else $error("input item changed while waiting");

endmodule

bind accel_ema_step_detector aesd_checker u_aesd_checker (.*);

`default_nettype wire
